FILE: hdl/icmp_rc_pkg.sv
package icmp_rc_pkg;

    localparam int unsigned IDX_W = 16;
    localparam int unsigned SUM_W = 16;
    localparam int unsigned CNT_W = 32;

    localparam logic [IDX_W-1:0] IDX_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // header byte offsets
    localparam logic [IDX_W-1:0] OFF_TYPE   = 16'd0;
    localparam logic [IDX_W-1:0] OFF_CODE   = 16'd1;
    localparam logic [IDX_W-1:0] OFF_CSUM_H = 16'd2;
    localparam logic [IDX_W-1:0] OFF_CSUM_L = 16'd3;
    localparam logic [IDX_W-1:0] OFF_ID_H   = 16'd4;
    localparam logic [IDX_W-1:0] OFF_ID_L   = 16'd5;
    localparam logic [IDX_W-1:0] OFF_SEQ_H  = 16'd6;
    localparam logic [IDX_W-1:0] OFF_SEQ_L  = 16'd7;

    localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
    localparam logic [7:0] TYPE_UNREACHABLE   = 8'd3;
    localparam logic [7:0] TYPE_ECHO_REQUEST  = 8'd8;
    localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;

    typedef enum logic [0:0] {
        OP_BYTE  = 1'b0,
        OP_CLEAR = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_DISABLED = 2'd1,
        ST_SHORT    = 2'd2,
        ST_MISMATCH = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CL_ECHO_REQUEST  = 3'd0,
        CL_ECHO_REPLY    = 3'd1,
        CL_UNREACHABLE   = 3'd2,
        CL_TIME_EXCEEDED = 3'd3,
        CL_OTHER         = 3'd4
    } t_msg_class;

endpackage

FILE: hdl/icmp_receive_checker.sv
// o_out_valid rises in the cycle after the beat carrying the last byte is taken.
// Throughput: one byte beat per cycle; the running sum takes a single
// 16-bit add with end-around carry per byte outside the checksum field.
// A result waiting in the output register stalls input for as long as
// i_out_ready is low, whatever the next beat carries.
// Reset (i_rst_n low, synchronous) clears enable, the sum, the header
// capture, the byte index and the echo-reply count.
module icmp_receive_checker
    import icmp_rc_pkg::*;
#(
    parameter int unsigned HEADER_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_enable,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_byte_value,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [2:0]  o_msg_class,
    output logic [7:0]  o_msg_type,
    output logic [7:0]  o_msg_code,
    output logic [15:0] o_identifier,
    output logic [15:0] o_sequence_res,
    output logic        o_send_reply,
    output logic [31:0] o_replies_seen
);

    localparam logic [IDX_W-1:0] HDR_LEN = IDX_W'(HEADER_BYTES);

    logic             r_enable;
    logic [SUM_W-1:0] r_sum,  n_sum;
    logic [IDX_W-1:0] r_idx,  n_idx;
    logic             r_odd;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_code, n_code;
    logic [15:0]      r_csum, n_csum;
    logic [15:0]      r_id,   n_id;
    logic [15:0]      r_seq,  n_seq;
    logic [CNT_W-1:0] r_count, n_count;

    logic             r_out_valid;
    t_status          r_status, n_status;
    t_msg_class       r_class,  n_class;
    logic             r_reply,  n_reply;

    logic             accept;
    logic             is_byte;
    logic             is_clear;
    logic             is_final;
    logic [SUM_W-1:0] word;
    logic [SUM_W:0]   raw_sum;
    logic [SUM_W-1:0] fold_sum;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign is_byte     = accept && (t_opcode'(i_opcode) == OP_BYTE);
    assign is_clear    = accept && (t_opcode'(i_opcode) == OP_CLEAR);
    assign is_final    = is_byte && i_last_byte;

    // even offsets are the high byte of the 16-bit word
    assign word     = r_odd ? {8'h00, i_byte_value} : {i_byte_value, 8'h00};
    assign raw_sum  = {1'b0, r_sum} + {1'b0, word};
    assign fold_sum = raw_sum[SUM_W-1:0] + SUM_W'(raw_sum[SUM_W]);

    always_comb begin
        n_type = r_type;
        n_code = r_code;
        n_csum = r_csum;
        n_id   = r_id;
        n_seq  = r_seq;
        n_sum  = fold_sum;
        unique case (r_idx)
            OFF_TYPE:   n_type       = i_byte_value;
            OFF_CODE:   n_code       = i_byte_value;
            OFF_CSUM_H: n_csum[15:8] = i_byte_value;
            OFF_CSUM_L: n_csum[7:0]  = i_byte_value;
            OFF_ID_H:   n_id[15:8]   = i_byte_value;
            OFF_ID_L:   n_id[7:0]    = i_byte_value;
            OFF_SEQ_H:  n_seq[15:8]  = i_byte_value;
            OFF_SEQ_L:  n_seq[7:0]   = i_byte_value;
            default: ;
        endcase
        // checksum field stays out of the sum
        if (r_idx == OFF_CSUM_H || r_idx == OFF_CSUM_L) begin
            n_sum = r_sum;
        end
        n_idx = (r_idx == IDX_MAX) ? r_idx : r_idx + 1'b1;
    end

    always_comb begin
        priority if (!r_enable) begin
            n_status = ST_DISABLED;
        end else if (n_idx < HDR_LEN) begin
            n_status = ST_SHORT;
        end else if (n_csum != ~n_sum) begin
            n_status = ST_MISMATCH;
        end else begin
            n_status = ST_ACCEPTED;
        end

        priority if (n_type == TYPE_ECHO_REQUEST) begin
            n_class = CL_ECHO_REQUEST;
        end else if (n_type == TYPE_ECHO_REPLY) begin
            n_class = CL_ECHO_REPLY;
        end else if (n_type == TYPE_UNREACHABLE) begin
            n_class = CL_UNREACHABLE;
        end else if (n_type == TYPE_TIME_EXCEEDED) begin
            n_class = CL_TIME_EXCEEDED;
        end else begin
            n_class = CL_OTHER;
        end

        n_reply = (n_status == ST_ACCEPTED) && (n_type == TYPE_ECHO_REQUEST);

        n_count = r_count;
        if (n_status == ST_ACCEPTED && n_type == TYPE_ECHO_REPLY
                && r_count != CNT_MAX) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_enable <= i_cfg_enable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_idx   <= '0;
            r_odd   <= 1'b0;
            r_type  <= '0;
            r_code  <= '0;
            r_csum  <= '0;
            r_id    <= '0;
            r_seq   <= '0;
            r_count <= '0;
        end else if (is_clear) begin
            r_count <= '0;
        end else if (is_final) begin
            // drop per-message state after the last byte
            r_sum   <= '0;
            r_idx   <= '0;
            r_odd   <= 1'b0;
            r_type  <= '0;
            r_code  <= '0;
            r_csum  <= '0;
            r_id    <= '0;
            r_seq   <= '0;
            r_count <= n_count;
        end else if (is_byte) begin
            r_sum  <= n_sum;
            r_idx  <= n_idx;
            r_odd  <= !r_odd;
            r_type <= n_type;
            r_code <= n_code;
            r_csum <= n_csum;
            r_id   <= n_id;
            r_seq  <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (is_final) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_final) begin
            r_status       <= n_status;
            r_class        <= n_class;
            r_reply        <= n_reply;
            o_msg_type     <= n_type;
            o_msg_code     <= n_code;
            o_identifier   <= n_id;
            o_sequence_res <= n_seq;
            o_replies_seen <= n_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_msg_class  = r_class;
    assign o_send_reply = r_reply;

endmodule

FILE: hdl/icmp_rc_checker.sv
module icmp_rc_checker
    import icmp_rc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [2:0]  o_msg_class,
    input logic [7:0]  o_msg_type,
    input logic        o_send_reply,
    input logic [31:0] o_replies_seen
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_status) && $stable(o_msg_type)
            && $stable(o_replies_seen))
        else $error("stalled result beat changed");

    a_reply_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_send_reply |-> o_status == ST_ACCEPTED
            && o_msg_class == CL_ECHO_REQUEST && o_msg_type == TYPE_ECHO_REQUEST)
        else $error("reply requested for a message that is not an accepted echo request");

    a_class_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_msg_type == TYPE_ECHO_REPLY |-> o_msg_class == CL_ECHO_REPLY)
        else $error("echo reply type reported with the wrong class");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while a result beat is stalled");

endmodule

bind icmp_receive_checker icmp_rc_checker u_icmp_rc_checker (.*);

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import icmp_rc_pkg::*;

    localparam int HEADER_BYTES = 8;

    typedef struct packed {
        t_status    status;
        t_msg_class msg_class;
        logic [7:0]  msg_type;
        logic [7:0]  msg_code;
        logic [15:0] identifier;
        logic [15:0] sequence_res;
        logic        send_reply;
        logic [31:0] replies_seen;
    } t_icmp_verdict;

    typedef struct packed {
        t_status    st;
        t_msg_class cls;
    } t_verdict_tag;

    typedef struct packed {
        t_opcode    op;
        logic [7:0] value;
        logic       last;
        logic       has_tag;
        t_status    st;
        t_msg_class cls;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_enable = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_opcode = 1'b0;
    logic [7:0]  i_byte_value = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [2:0]  o_msg_class;
    logic [7:0]  o_msg_type;
    logic [7:0]  o_msg_code;
    logic [15:0] o_identifier;
    logic [15:0] o_sequence_res;
    logic        o_send_reply;
    logic [31:0] o_replies_seen;

    icmp_receive_checker #(
        .HEADER_BYTES (HEADER_BYTES)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_enable   (i_cfg_enable),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_byte_value   (i_byte_value),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_msg_class    (o_msg_class),
        .o_msg_type     (o_msg_type),
        .o_msg_code     (o_msg_code),
        .o_identifier   (o_identifier),
        .o_sequence_res (o_sequence_res),
        .o_send_reply   (o_send_reply),
        .o_replies_seen (o_replies_seen)
    );

    // checker's own copy of the block state
    logic        pr_enable = 1'b0;
    logic [15:0] pr_sum = '0;
    logic [15:0] pr_index = '0;
    logic        pr_odd = 1'b0;
    logic [7:0]  pr_type = '0;
    logic [7:0]  pr_code = '0;
    logic [15:0] pr_csum = '0;
    logic [15:0] pr_ident = '0;
    logic [15:0] pr_seq = '0;
    logic [31:0] pr_replies = '0;

    t_icmp_verdict expected_verdicts[$];
    t_verdict_tag  expected_tags[$];
    int mismatch_count = 0;
    int beats_sent = 0;
    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    t_dir_row directed_rows [27] = '{
        '{OP_BYTE,  8'h08, 1'b1, 1'b1, ST_DISABLED, CL_ECHO_REQUEST},
        '{OP_BYTE,  8'hFF, 1'b1, 1'b1, ST_SHORT,    CL_OTHER},
        '{OP_BYTE,  8'h08, 1'b0, 1'b0, ST_ACCEPTED, CL_OTHER},
        '{OP_BYTE,  8'h00, 1'b0, 1'b0, ST_ACCEPTED, CL_OTHER},
        '{OP_BYTE,  8'hE5, 1'b0, 1'b0, ST_ACCEPTED, CL_OTHER},
        '{OP_BYTE,  8'hCA, 1'b0, 1'b0, ST_ACCEPTED, CL_OTHER},
        '{OP_BYTE,  8'h12, 1'b0, 1'b0, ST_ACCEPTED, CL_OTHER},
        '{OP_BYTE,  8'h34, 1'b0, 1'b0, ST_ACCEPTED, CL_OTHER},
        '{OP_CLEAR, 8'hFF, 1'b1, 1'b0, ST_ACCEPTED, CL_OTHER},
        '{OP_BYTE,  8'h00, 1'b0, 1'b0, ST_ACCEPTED, CL_OTHER},
        '{OP_BYTE,  8'h01, 1'b1, 1'b1, ST_ACCEPTED, CL_ECHO_REQUEST},
        '{OP_BYTE,  8'h00, 1'b0, 1'b0, ST_ACCEPTED, CL_OTHER},
        '{OP_BYTE,  8'h00, 1'b0, 1'b0, ST_ACCEPTED, CL_OTHER},
        '{OP_BYTE,  8'h00, 1'b0, 1'b0, ST_ACCEPTED, CL_OTHER},
        '{OP_BYTE,  8'h00, 1'b0, 1'b0, ST_ACCEPTED, CL_OTHER},
        '{OP_BYTE,  8'hFF, 1'b0, 1'b0, ST_ACCEPTED, CL_OTHER},
        '{OP_BYTE,  8'hFF, 1'b0, 1'b0, ST_ACCEPTED, CL_OTHER},
        '{OP_BYTE,  8'hFF, 1'b0, 1'b0, ST_ACCEPTED, CL_OTHER},
        '{OP_BYTE,  8'hFF, 1'b1, 1'b1, ST_ACCEPTED, CL_ECHO_REPLY},
        '{OP_BYTE,  8'h0B, 1'b0, 1'b0, ST_ACCEPTED, CL_OTHER},
        '{OP_BYTE,  8'h00, 1'b0, 1'b0, ST_ACCEPTED, CL_OTHER},
        '{OP_BYTE,  8'h00, 1'b0, 1'b0, ST_ACCEPTED, CL_OTHER},
        '{OP_BYTE,  8'h00, 1'b0, 1'b0, ST_ACCEPTED, CL_OTHER},
        '{OP_BYTE,  8'h00, 1'b0, 1'b0, ST_ACCEPTED, CL_OTHER},
        '{OP_BYTE,  8'h00, 1'b0, 1'b0, ST_ACCEPTED, CL_OTHER},
        '{OP_BYTE,  8'h00, 1'b0, 1'b0, ST_ACCEPTED, CL_OTHER},
        '{OP_BYTE,  8'h00, 1'b1, 1'b1, ST_MISMATCH, CL_TIME_EXCEEDED}
    };

    function automatic logic [15:0] fold_add(input logic [15:0] s, input logic [15:0] w);
        logic [16:0] t;
        t = {1'b0, s} + {1'b0, w};
        return t[15:0] + {15'd0, t[16]};
    endfunction

    function automatic t_msg_class class_of(input logic [7:0] t);
        case (t)
            TYPE_ECHO_REQUEST:  return CL_ECHO_REQUEST;
            TYPE_ECHO_REPLY:    return CL_ECHO_REPLY;
            TYPE_UNREACHABLE:   return CL_UNREACHABLE;
            TYPE_TIME_EXCEEDED: return CL_TIME_EXCEEDED;
            default:            return CL_OTHER;
        endcase
    endfunction

    // Fold one beat into the message state; returns 1 when a verdict is due.
    function automatic bit absorb_byte(input t_opcode op, input logic [7:0] b,
                                       input logic last, output t_icmp_verdict v);
        logic [15:0] idx;
        v = '0;
        if (op == OP_CLEAR) begin
            pr_replies = '0;
            return 1'b0;
        end
        idx = pr_index;
        case (idx)
            OFF_TYPE:   pr_type = b;
            OFF_CODE:   pr_code = b;
            OFF_CSUM_H: pr_csum[15:8] = b;
            OFF_CSUM_L: pr_csum[7:0] = b;
            OFF_ID_H:   pr_ident[15:8] = b;
            OFF_ID_L:   pr_ident[7:0] = b;
            OFF_SEQ_H:  pr_seq[15:8] = b;
            OFF_SEQ_L:  pr_seq[7:0] = b;
            default: ;
        endcase
        if (idx != OFF_CSUM_H && idx != OFF_CSUM_L)
            pr_sum = fold_add(pr_sum, pr_odd ? {8'h00, b} : {b, 8'h00});
        pr_odd = ~pr_odd;
        if (pr_index != IDX_MAX)
            pr_index = pr_index + 16'd1;
        if (!last)
            return 1'b0;

        if (!pr_enable)
            v.status = ST_DISABLED;
        else if (pr_index < HEADER_BYTES)
            v.status = ST_SHORT;
        else if (pr_csum != ~pr_sum)
            v.status = ST_MISMATCH;
        else
            v.status = ST_ACCEPTED;

        if (v.status == ST_ACCEPTED) begin
            if (pr_type == TYPE_ECHO_REQUEST)
                v.send_reply = 1'b1;
            else if (pr_type == TYPE_ECHO_REPLY && pr_replies != CNT_MAX)
                pr_replies = pr_replies + 32'd1;
        end
        v.msg_class    = class_of(pr_type);
        v.msg_type     = pr_type;
        v.msg_code     = pr_code;
        v.identifier   = pr_ident;
        v.sequence_res = pr_seq;
        v.replies_seen = pr_replies;

        pr_sum   = '0;
        pr_index = '0;
        pr_odd   = 1'b0;
        pr_type  = '0;
        pr_code  = '0;
        pr_csum  = '0;
        pr_ident = '0;
        pr_seq   = '0;
        return 1'b1;
    endfunction

    // Checksum that makes a message pass: skip the checksum field itself.
    function automatic logic [15:0] ones_checksum(input logic [7:0] m[$]);
        logic [15:0] s;
        s = '0;
        for (int p = 0; p < m.size(); p++)
            if (p != 2 && p != 3)
                s = fold_add(s, p[0] ? {8'h00, m[p]} : {m[p], 8'h00});
        return ~s;
    endfunction

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // Receiver: random stalls, plus long hold-offs on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : scoreboard
        t_icmp_verdict got_v;
        t_icmp_verdict exp_v;
        t_verdict_tag  tag;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got_v.status       = t_status'(o_status);
                got_v.msg_class    = t_msg_class'(o_msg_class);
                got_v.msg_type     = o_msg_type;
                got_v.msg_code     = o_msg_code;
                got_v.identifier   = o_identifier;
                got_v.sequence_res = o_sequence_res;
                got_v.send_reply   = o_send_reply;
                got_v.replies_seen = o_replies_seen;
                if (expected_verdicts.size() == 0) begin
                    $error("result beat with no expectation pending");
                    mismatch_count++;
                end else begin
                    exp_v = expected_verdicts.pop_front();
                    if (got_v.status !== exp_v.status) begin
                        $error("status: expected %0d, got %0d", exp_v.status, o_status);
                        mismatch_count++;
                    end
                    if (got_v.msg_class !== exp_v.msg_class) begin
                        $error("msg_class: expected %0d, got %0d",
                               exp_v.msg_class, o_msg_class);
                        mismatch_count++;
                    end
                    if (got_v.msg_type !== exp_v.msg_type) begin
                        $error("msg_type: expected %0h, got %0h", exp_v.msg_type, o_msg_type);
                        mismatch_count++;
                    end
                    if (got_v.msg_code !== exp_v.msg_code) begin
                        $error("msg_code: expected %0h, got %0h", exp_v.msg_code, o_msg_code);
                        mismatch_count++;
                    end
                    if (got_v.identifier !== exp_v.identifier) begin
                        $error("identifier: expected %0h, got %0h",
                               exp_v.identifier, o_identifier);
                        mismatch_count++;
                    end
                    if (got_v.sequence_res !== exp_v.sequence_res) begin
                        $error("sequence_res: expected %0h, got %0h",
                               exp_v.sequence_res, o_sequence_res);
                        mismatch_count++;
                    end
                    if (got_v.send_reply !== exp_v.send_reply) begin
                        $error("send_reply: expected %0b, got %0b",
                               exp_v.send_reply, o_send_reply);
                        mismatch_count++;
                    end
                    if (got_v.replies_seen !== exp_v.replies_seen) begin
                        $error("replies_seen: expected %0d, got %0d",
                               exp_v.replies_seen, o_replies_seen);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                pr_enable = i_cfg_enable;
            if (i_in_valid && o_in_ready) begin
                if (absorb_byte(t_opcode'(i_opcode), i_byte_value, i_last_byte, exp_v)) begin
                    // directed rows carry their status and class by hand
                    if (expected_tags.size() != 0) begin
                        tag = expected_tags.pop_front();
                        exp_v.status = tag.st;
                        exp_v.msg_class = tag.cls;
                    end
                    expected_verdicts.push_back(exp_v);
                end
            end
        end
    end

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_beat(input t_opcode op, input logic [7:0] b, input logic last);
        int gap;
        if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_byte_value <= b;
        i_last_byte  <= last;
        do @(posedge i_clk); while (!o_in_ready);
        beats_sent++;
    endtask

    task automatic send_message(input logic [7:0] m[$], input bit mix_clears);
        foreach (m[k]) begin
            if (mix_clears && $urandom_range(0, 99) < 4)
                send_beat(OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            send_beat(OP_BYTE, m[k], k == m.size() - 1);
        end
    endtask

    task automatic send_random_message();
        logic [7:0]  m[$];
        int          kind;
        int          len;
        logic [15:0] cs;
        kind = $urandom_range(0, 99);
        if (kind < 82) begin
            len = 8 + $urandom_range(0, 12);
            for (int k = 0; k < len; k++)
                m.push_back(8'($urandom_range(0, 255)));
            case ($urandom_range(0, 5))
                0: m[0] = TYPE_ECHO_REQUEST;
                1: m[0] = TYPE_ECHO_REPLY;
                2: m[0] = TYPE_UNREACHABLE;
                3: m[0] = TYPE_TIME_EXCEEDED;
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0)
                m[1] = 8'h00;
            cs = ones_checksum(m);
            // corrupt some checksums
            if (kind >= 70)
                cs = cs ^ 16'($urandom_range(1, 65535));
            m[2] = cs[15:8];
            m[3] = cs[7:0];
        end else begin
            len = (kind < 92) ? $urandom_range(1, HEADER_BYTES - 1) : $urandom_range(1, 20);
            for (int k = 0; k < len; k++)
                m.push_back(8'($urandom_range(0, 255)));
        end
        send_message(m, 1'b1);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_enable(input logic en);
        wait_drained();
        i_cfg_valid  <= 1'b1;
        i_cfg_enable <= en;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int idle, input int stall, input logic en,
                             input int beats, input bit squeeze);
        int start;
        write_enable(en);
        in_idle_pct   = idle;
        out_stall_pct = stall;
        start = beats_sent;
        if (squeeze) begin
            // hold the output off while single-byte messages keep coming
            hold_request = 60;
            repeat (40) send_beat(OP_BYTE, 8'($urandom_range(0, 255)), 1'b1);
        end
        while (beats_sent - start < beats)
            send_random_message();
        wait_drained();
    endtask

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // enable is still at its reset value for the first row
        for (int i = 0; i < 27; i++) begin
            if (i == 1)
                write_enable(1'b1);
            if (directed_rows[i].has_tag)
                expected_tags.push_back(t_verdict_tag'{directed_rows[i].st,
                                                       directed_rows[i].cls});
            send_beat(directed_rows[i].op, directed_rows[i].value, directed_rows[i].last);
        end
        wait_drained();

        run_phase(0, 0, 1'b1, 250, 1'b1);
        run_phase(49, 0, 1'b1, 250, 1'b0);
        run_phase(0, 49, 1'b0, 150, 1'b0);
        run_phase(20, 20, 1'b1, 250, 1'b0);
        run_phase(0, 0, 1'b1, 250, 1'b0);
        repeat (4) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
